// ----- hdl/cqd_pkg.sv -----
// Shared types, constants and the reciprocal table of the coefficient quantizer.
// Used by every module of the block; no dependencies of its own.
package cqd_pkg;

    localparam int MODE_W   = 2;
    localparam int COEF_W   = 13;
    localparam int POS_W    = 6;
    localparam int STEP_W   = 5;
    localparam int VALUE_W  = 19;

    // Block geometry: position zero is the DC coefficient
    localparam int BLOCK_ELEMENTS = 64;

    // Reciprocal divide: floor(n / s) = (n * ceil(2^19 / s)) >> 19 holds exactly
    // for every n below 2^13 and s in 1..31
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 20;
    localparam int OPA_W       = 14;
    localparam int OPB_W       = RECIP_W;
    localparam int PROD_W      = OPA_W + OPB_W;
    localparam int INV_MAG_W   = 18;

    localparam int LEVEL_MAX   = 127;
    localparam int FLAT_DC_MIN = 1;
    localparam int FLAT_DC_MAX = 254;

    typedef enum logic [MODE_W-1:0] {
        MODE_FWD_NORMAL  = 2'd0,
        MODE_FWD_FLAT_DC = 2'd1,
        MODE_INV_NORMAL  = 2'd2,
        MODE_INV_FLAT_DC = 2'd3
    } t_mode;

    // Operation class chosen by the front end
    typedef enum logic [1:0] {
        KIND_FWD_LEVEL = 2'd0,
        KIND_FWD_DC    = 2'd1,
        KIND_INV       = 2'd2
    } t_kind;

    // Classified item handed from the front end to the arithmetic back end
    typedef struct packed {
        t_kind              kind;
        logic               neg;       // result sign (forward DC: coefficient <= 0)
        logic               zero;      // inverse of a zero level
        logic               even_adj;  // pull magnitude one toward zero
        logic [OPA_W-1:0]   opa;       // magnitude operand
        logic [OPB_W-1:0]   opb;       // reciprocal or step
    } t_cqd_op;

    // ceil(2^19 / s); a step of zero acts as a step of one
    function automatic logic [RECIP_W-1:0] recip(input logic [STEP_W-1:0] s);
        logic [RECIP_W-1:0] r;
        unique case (s)
            5'd0:  r = 20'd524288;
            5'd1:  r = 20'd524288;
            5'd2:  r = 20'd262144;
            5'd3:  r = 20'd174763;
            5'd4:  r = 20'd131072;
            5'd5:  r = 20'd104858;
            5'd6:  r = 20'd87382;
            5'd7:  r = 20'd74899;
            5'd8:  r = 20'd65536;
            5'd9:  r = 20'd58255;
            5'd10: r = 20'd52429;
            5'd11: r = 20'd47663;
            5'd12: r = 20'd43691;
            5'd13: r = 20'd40330;
            5'd14: r = 20'd37450;
            5'd15: r = 20'd34953;
            5'd16: r = 20'd32768;
            5'd17: r = 20'd30841;
            5'd18: r = 20'd29128;
            5'd19: r = 20'd27595;
            5'd20: r = 20'd26215;
            5'd21: r = 20'd24967;
            5'd22: r = 20'd23832;
            5'd23: r = 20'd22796;
            5'd24: r = 20'd21846;
            5'd25: r = 20'd20972;
            5'd26: r = 20'd20165;
            5'd27: r = 20'd19419;
            5'd28: r = 20'd18725;
            5'd29: r = 20'd18079;
            5'd30: r = 20'd17477;
            5'd31: r = 20'd16913;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/coefficient_quantizer_dequantizer_core.sv -----
// Coefficient quantizer / dequantizer top level.
// Instantiates cqd_front, cqd_queue and cqd_back; depends on cqd_pkg.
//
// Usage:
//   The slave stream carries one coefficient (forward modes) or one level
//   (inverse modes) per transfer, with its block position and both steps in
//   tdata and the mode in tuser. The master stream returns one quantized
//   level or restored coefficient per input transfer, in order.
//   Throughput: one item per cycle while the receiver is ready, set by
//   the single multiplier stage of the back end, which takes one every cycle.
//   The edge of an input transfer writes the item into the queue; from there
//   it moves through the multiply register into the output register, without
//   waiting while the receiver is ready.
//   A front end classifies each item and writes it into a QUEUE_DEPTH entry
//   queue; the back end multiplies by a reciprocal or the step, then clamps.
//   When the receiver stalls, the output register holds its result, the back
//   end fills, then the queue fills, and s_axis_tready drops only once the
//   queue is full.
//   Reset (i_rst_n low, synchronous) empties the queue and the pipeline; no
//   other state exists.
module coefficient_quantizer_dequantizer_core
    import cqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // coefficient[12:0], position[18:13],
                                         // dc_step[23:19], ac_step[28:24], zero
    input  logic [1:0]   s_axis_tuser,   // mode[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata    // value[18:0], zero
);

    t_cqd_op             front_op;
    t_cqd_op             queue_op;
    logic                queue_full;
    logic                queue_valid;
    logic                back_pop;
    logic [VALUE_W-1:0]  back_value;

    assign s_axis_tready = ~queue_full;
    assign m_axis_tdata  = {5'b0, back_value};

    cqd_front u_front (
        .i_mode        (s_axis_tuser),
        .i_coefficient (s_axis_tdata[12:0]),
        .i_position    (s_axis_tdata[18:13]),
        .i_dc_step     (s_axis_tdata[23:19]),
        .i_ac_step     (s_axis_tdata[28:24]),
        .o_op          (front_op)
    );

    cqd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_op    (front_op),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_op    (queue_op)
    );

    cqd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_op    (queue_op),
        .o_pop   (back_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (back_value)
    );

endmodule

// ----- hdl/cqd_front.sv -----
// Front end of the coefficient quantizer: classifies one input item into an
// operation class and multiplier operands. Depends on cqd_pkg.
module cqd_front
    import cqd_pkg::*;
(
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [COEF_W-1:0]  i_coefficient,
    input  logic [POS_W-1:0]   i_position,
    input  logic [STEP_W-1:0]  i_dc_step,
    input  logic [STEP_W-1:0]  i_ac_step,
    output t_cqd_op            o_op
);

    logic                is_dc;
    logic [STEP_W-1:0]   step_raw;
    logic [STEP_W-1:0]   step;
    logic                even;
    logic                neg_c;
    logic                zero_c;
    logic [COEF_W-1:0]   abs_c;
    logic [STEP_W-2:0]   half;
    logic [OPA_W-1:0]    fwd_mag;
    logic [OPA_W-1:0]    inv_mag;
    t_mode               mode;

    // Select the step and take the coefficient apart into sign and magnitude
    assign mode     = t_mode'(i_mode);
    assign is_dc    = (i_position == POS_W'(0));
    assign step_raw = is_dc ? i_dc_step : i_ac_step;
    assign step     = (step_raw == '0) ? STEP_W'(1) : step_raw;
    assign even     = ~step[0];
    assign half     = step[STEP_W-1:1];
    assign neg_c    = i_coefficient[COEF_W-1];
    assign zero_c   = (i_coefficient == '0);
    assign abs_c    = neg_c ? (~i_coefficient + COEF_W'(1)) : i_coefficient;
    assign fwd_mag  = {1'b0, abs_c} + OPA_W'(even);
    assign inv_mag  = {abs_c, 1'b1};

    // Classify the item
    always_comb begin
        o_op          = '0;
        o_op.kind     = KIND_FWD_LEVEL;
        o_op.neg      = neg_c;
        o_op.zero     = zero_c;
        o_op.even_adj = 1'b0;
        o_op.opa      = fwd_mag;
        o_op.opb      = recip(step);
        unique case (mode)
            MODE_FWD_NORMAL: begin
                o_op.kind = KIND_FWD_LEVEL;
            end
            MODE_FWD_FLAT_DC: begin
                if (is_dc) begin
                    o_op.kind = KIND_FWD_DC;
                    o_op.neg  = neg_c | zero_c;
                    o_op.opa  = {1'b0, abs_c} + OPA_W'(half);
                end
            end
            MODE_INV_NORMAL: begin
                o_op.kind     = KIND_INV;
                o_op.even_adj = even;
                o_op.opa      = inv_mag;
                o_op.opb      = OPB_W'(step);
            end
            MODE_INV_FLAT_DC: begin
                o_op.kind = KIND_INV;
                o_op.opb  = OPB_W'(step);
                if (is_dc) begin
                    o_op.opa = {1'b0, abs_c};
                end else begin
                    o_op.even_adj = even;
                    o_op.opa      = inv_mag;
                end
            end
        endcase
    end

endmodule

// ----- hdl/cqd_queue.sv -----
// Short queue of classified items between the front and back ends.
// Depends on cqd_pkg for the item type.
module cqd_queue
    import cqd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_cqd_op  i_op,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_cqd_op  o_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cqd_op            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               push_en;
    logic               pop_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd];
    assign push_en = i_push & ~o_full;
    assign pop_en  = i_pop & o_valid;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr] <= i_op;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_en) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop_en) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(push_en) - CNT_W'(pop_en);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == $past(r_count) + CNT_W'($past(push_en))
                                     - CNT_W'($past(pop_en)))
        else $error("queue occupancy does not follow transfers");

endmodule

// ----- hdl/cqd_back.sv -----
// Back end of the coefficient quantizer: shared multiplier stage, then
// rounding, clamping and sign restore into the output register. Depends on cqd_pkg.
module cqd_back
    import cqd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_cqd_op              i_op,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [VALUE_W-1:0]   o_value
);

    logic                   r_s1_valid;
    t_kind                  r_s1_kind;
    logic                   r_s1_neg;
    logic                   r_s1_zero;
    logic                   r_s1_even;
    logic [PROD_W-1:0]      r_s1_prod;

    logic                   r_s2_valid;
    t_kind                  r_s2_kind;
    logic [VALUE_W-1:0]     r_s2_value;

    logic                   s1_ready;
    logic                   s2_ready;
    logic [PROD_W-RECIP_SHIFT-2:0] lvl_q;
    logic [PROD_W-RECIP_SHIFT-1:0] dc_q;
    logic [INV_MAG_W-1:0]   inv_mag;
    logic [VALUE_W-1:0]     mag;
    logic [VALUE_W-1:0]     n_value;

    // Pipeline flow control
    assign s2_ready = ~r_s2_valid | i_ready;
    assign s1_ready = ~r_s1_valid | s2_ready;
    assign o_pop    = i_valid & s1_ready;
    assign o_valid  = r_s2_valid;
    assign o_value  = r_s2_value;

    // Stage one: one multiply, reciprocal for forward, step for inverse
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_kind <= i_op.kind;
            r_s1_neg  <= i_op.neg;
            r_s1_zero <= i_op.zero;
            r_s1_even <= i_op.even_adj;
            r_s1_prod <= PROD_W'(i_op.opa) * PROD_W'(i_op.opb);
        end
    end

    // Stage two: pick quotient or product, clamp and restore sign
    assign lvl_q   = r_s1_prod[PROD_W-1:RECIP_SHIFT+1];
    assign dc_q    = r_s1_prod[PROD_W-1:RECIP_SHIFT];
    assign inv_mag = r_s1_prod[INV_MAG_W-1:0] - INV_MAG_W'(r_s1_even);

    always_comb begin
        mag     = '0;
        n_value = '0;
        unique case (r_s1_kind)
            KIND_FWD_LEVEL: begin
                mag     = (lvl_q > ($bits(lvl_q))'(LEVEL_MAX)) ? VALUE_W'(LEVEL_MAX)
                                                              : VALUE_W'(lvl_q);
                n_value = r_s1_neg ? (~mag + VALUE_W'(1)) : mag;
            end
            KIND_FWD_DC: begin
                if (r_s1_neg || dc_q == '0) begin
                    n_value = VALUE_W'(FLAT_DC_MIN);
                end else if (dc_q > ($bits(dc_q))'(FLAT_DC_MAX)) begin
                    n_value = VALUE_W'(FLAT_DC_MAX);
                end else begin
                    n_value = VALUE_W'(dc_q);
                end
            end
            KIND_INV: begin
                // magnitude stays below 2^18, so the output range is never reached
                mag     = r_s1_zero ? '0 : {1'b0, inv_mag};
                n_value = r_s1_neg ? (~mag + VALUE_W'(1)) : mag;
            end
            default: begin
                n_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && r_s1_valid) begin
            r_s2_kind  <= r_s1_kind;
            r_s2_value <= n_value;
        end
    end

    // Valid flags of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_kind == KIND_FWD_LEVEL) |->
            ($signed(r_s2_value) <= LEVEL_MAX && $signed(r_s2_value) >= -LEVEL_MAX))
        else $error("forward level outside clamp range");

    a_dc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_kind == KIND_FWD_DC) |->
            ($signed(r_s2_value) >= FLAT_DC_MIN && $signed(r_s2_value) <= FLAT_DC_MAX))
        else $error("flat DC level outside clamp range");

endmodule
